>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

>>> rtl/obo_pkg.sv
// shared constants, types and helpers of the opening overlay block
package obo_pkg;

  localparam int IMG_W   = 128;
  localparam int IMG_H   = 128;
  localparam int COL_W   = $clog2(IMG_W);
  // rows run past the image while the pipeline drains
  localparam int ROW_W   = $clog2(IMG_H + 4);
  localparam int PIX_W   = 8;
  localparam int NSTREAM = 3;

  localparam logic [PIX_W-1:0] PIX_FULL     = '1;
  localparam logic [PIX_W-1:0] THRESH_RESET = PIX_W'(150);

  // bit streams kept in the line memory
  localparam int STR_BIN = 0;
  localparam int STR_ERO = 1;
  localparam int STR_OPN = 2;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } obo_cmd_t;

  typedef enum logic {
    OP_DILATE = 1'b0,
    OP_ERODE  = 1'b1
  } obo_op_t;

  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } obo_mask_t;

  typedef struct packed {
    logic [NSTREAM-1:0] near;
    logic [NSTREAM-1:0] far;
    logic [PIX_W-1:0]   gray_a;
    logic [PIX_W-1:0]   gray_b;
    logic [PIX_W-1:0]   gray_c;
  } obo_word_t;

  // which neighbors of a window center lie inside the image
  function automatic obo_mask_t border_mask(input logic [ROW_W-1:0] row,
                                            input logic [COL_W-1:0] col);
    obo_mask_t m;
    m.up    = (row != '0);
    m.down  = (row < ROW_W'(IMG_H - 1));
    m.left  = (col != '0);
    m.right = (col < COL_W'(IMG_W - 1));
    return m;
  endfunction

endpackage

>>> rtl/obo_pixel_if.sv
// pixel request channel: command and gray value
interface obo_pixel_if;
  import obo_pkg::*;

  logic             valid;
  logic             ready;
  logic             command;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, command, pixel, input ready);
  modport sink   (input valid, command, pixel, output ready);
endinterface

>>> rtl/obo_result_if.sv
// result request channel: overlaid color pixel
interface obo_result_if;
  import obo_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;
  logic             frame_last;

  modport source (output valid, red, green, blue, frame_last, input ready);
  modport sink   (input valid, red, green, blue, frame_last, output ready);
endinterface

>>> rtl/binary_opening_boundary_overlay_unit.sv
// top level: thresholding, opening and boundary overlay over one line memory
//
// Takes one pixel request per clock and gives one result per clock once
// the pipeline is filled: the result for a pixel comes out with the request
// that arrives 3*WIDTH+3 positions later, so a frame is followed by
// 3*WIDTH+3 flush requests to drain it. Requests past the last pixel count
// as flush, flush requests inside the frame count as black pixels. The
// state is one line memory of WIDTH words (three bit streams two rows deep
// and three gray row delays) with one read and one write port, read one
// column ahead so that every request sees its column at once. Edge taps are
// masked from the frame counters, so old memory contents never show and no
// clearing pass runs at reset or between frames. Ready stays low for one
// cycle after reset while the first read is issued. An output register
// parts the two channels; a request is taken while the result register is
// empty or being drained. The user writes the threshold through cfg_wen
// and cfg_wdata between frames only; the block does not enforce this.
module binary_opening_boundary_overlay_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [obo_pkg::PIX_W-1:0] cfg_wdata,
  obo_pixel_if.sink                 pixels,
  obo_result_if.source              results
);
  import obo_pkg::*;

  localparam int NSTAGE  = 3;
  localparam int STG_ERO = 1;
  localparam int STG_OPN = 2;
  localparam int STG_OUT = 3;

  logic             primed;
  logic [PIX_W-1:0] thr;
  logic [COL_W-1:0] cp;
  logic [ROW_W-1:0] rp;
  logic [COL_W-1:0] cp_next;
  logic [ROW_W-1:0] rp_next;

  logic             res_valid;
  logic [PIX_W-1:0] res_red;
  logic [PIX_W-1:0] res_green;
  logic [PIX_W-1:0] res_blue;
  logic             res_last;

  logic [PIX_W-1:0] h1;
  logic [PIX_W-1:0] h2;
  logic [PIX_W-1:0] h3;

  logic             acc;
  logic             is_pixel;
  logic             bit_in;
  logic [PIX_W-1:0] gray_in;
  logic             last;

  logic [COL_W-1:0] st_col [1:NSTAGE];
  logic [ROW_W-1:0] st_row [1:NSTAGE];
  logic             st_act [1:NSTAGE];
  obo_mask_t        st_mask [1:NSTAGE];

  obo_word_t        rdata;
  obo_word_t        wdata;
  logic [COL_W-1:0] raddr;

  logic ero_bit;
  logic opn_bit;
  logic dil_bit;
  logic op_bit;
  logic bin_center;
  logic ero_center;

  assign pixels.ready = primed && (!res_valid || results.ready);
  assign acc          = pixels.valid && pixels.ready;

  assign is_pixel = (pixels.command == CMD_PIXEL) && (rp < ROW_W'(IMG_H));
  assign gray_in  = is_pixel ? pixels.pixel : '0;
  assign bit_in   = is_pixel && (pixels.pixel >= thr);

  // window center of each stage trails the request by stage*(WIDTH+1)
  always_comb begin
    for (int s = 1; s <= NSTAGE; s++) begin
      logic wrap;
      wrap = (cp < COL_W'(s));
      st_col[s]  = wrap ? COL_W'({1'b0, cp} + (COL_W + 1)'(IMG_W - s))
                        : COL_W'(cp - COL_W'(s));
      st_row[s]  = ROW_W'(rp - ROW_W'(s) - ROW_W'(wrap));
      st_act[s]  = (rp > ROW_W'(s)) || ((rp == ROW_W'(s)) && !wrap);
      st_mask[s] = border_mask(st_row[s], st_col[s]);
    end
  end

  assign last = st_act[STG_OUT] && (st_row[STG_OUT] == ROW_W'(IMG_H - 1))
                && (st_col[STG_OUT] == COL_W'(IMG_W - 1));

  always_comb begin
    cp_next = cp;
    rp_next = rp;
    if (last) begin
      cp_next = '0;
      rp_next = '0;
    end else if (cp == COL_W'(IMG_W - 1)) begin
      cp_next = '0;
      rp_next = rp + 1'b1;
    end else begin
      cp_next = cp + 1'b1;
    end
  end

  // read the column of the next request
  assign raddr = acc ? cp_next : cp;

  always_comb begin
    wdata.near   = '0;
    wdata.near[STR_BIN] = bit_in;
    wdata.near[STR_ERO] = ero_bit;
    wdata.near[STR_OPN] = opn_bit;
    wdata.far    = rdata.near;
    wdata.gray_a = gray_in;
    wdata.gray_b = rdata.gray_a;
    wdata.gray_c = rdata.gray_b;
  end

  obo_line_mem u_line_mem (
    .clk   (clk),
    .we    (acc),
    .waddr (cp),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  obo_window u_win_bin (
    .clk     (clk),
    .step    (acc),
    .op      (OP_ERODE),
    .rd_near (rdata.near[STR_BIN]),
    .rd_far  (rdata.far[STR_BIN]),
    .new_val (bit_in),
    .mask    (st_mask[STG_ERO]),
    .result  (ero_bit),
    .center  (bin_center)
  );

  obo_window u_win_ero (
    .clk     (clk),
    .step    (acc),
    .op      (OP_DILATE),
    .rd_near (rdata.near[STR_ERO]),
    .rd_far  (rdata.far[STR_ERO]),
    .new_val (ero_bit),
    .mask    (st_mask[STG_OPN]),
    .result  (opn_bit),
    .center  (ero_center)
  );

  obo_window u_win_opn (
    .clk     (clk),
    .step    (acc),
    .op      (OP_DILATE),
    .rd_near (rdata.near[STR_OPN]),
    .rd_far  (rdata.far[STR_OPN]),
    .new_val (opn_bit),
    .mask    (st_mask[STG_OUT]),
    .result  (dil_bit),
    .center  (op_bit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      primed    <= 1'b0;
      thr       <= THRESH_RESET;
      cp        <= '0;
      rp        <= '0;
      res_valid <= 1'b0;
    end else begin
      primed <= 1'b1;
      if (cfg_wen) begin
        thr <= cfg_wdata;
      end
      if (acc) begin
        cp <= cp_next;
        rp <= rp_next;
      end
      if (acc && st_act[STG_OUT]) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // last three gray positions after the row delays
  always_ff @(posedge clk) begin
    if (acc) begin
      h1 <= rdata.gray_c;
      h2 <= h1;
      h3 <= h2;
    end
    if (acc && st_act[STG_OUT]) begin
      res_red   <= op_bit ? PIX_FULL : h3;
      res_green <= (dil_bit && !op_bit) ? PIX_FULL : h3;
      res_blue  <= h3;
      res_last  <= last;
    end
  end

  assign results.valid      = res_valid;
  assign results.red        = res_red;
  assign results.green      = res_green;
  assign results.blue       = res_blue;
  assign results.frame_last = res_last;

  // window centers of the first two streams are not needed at the output
  logic unused_centers;
  assign unused_centers = bin_center ^ ero_center;
endmodule

>>> rtl/obo_line_mem.sv
// one-row line memory, one write and one registered read per cycle
module obo_line_mem (
  input  logic                     clk,
  input  logic                     we,
  input  logic [obo_pkg::COL_W-1:0] waddr,
  input  obo_pkg::obo_word_t       wdata,
  input  logic [obo_pkg::COL_W-1:0] raddr,
  output obo_pkg::obo_word_t       rdata
);
  import obo_pkg::*;

  obo_word_t store [0:IMG_W-1];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= store[raddr];
  end
endmodule

>>> rtl/obo_window.sv
// 3x3 cross window over one bit stream, erosion or dilation
module obo_window (
  input  logic               clk,
  input  logic               step,
  input  obo_pkg::obo_op_t   op,
  input  logic               rd_near,
  input  logic               rd_far,
  input  logic               new_val,
  input  obo_pkg::obo_mask_t mask,
  output logic               result,
  output logic               center
);
  import obo_pkg::*;

  // cur: one row below center, s1: center, s2: left, t1: one row above
  logic cur;
  logic s1;
  logic s2;
  logic t1;
  logic [4:0] taps;

  always_ff @(posedge clk) begin
    if (step) begin
      cur <= new_val;
      s1  <= rd_near;
      s2  <= s1;
      t1  <= rd_far;
    end
  end

  // taps outside the image read as zero
  always_comb begin
    taps[0] = s1;
    taps[1] = t1 & mask.up;
    taps[2] = cur & mask.down;
    taps[3] = s2 & mask.left;
    taps[4] = rd_near & mask.right;
    case (op)
      OP_ERODE:  result = &taps;
      OP_DILATE: result = |taps;
      default:   result = 1'b0;
    endcase
  end

  assign center = s1;
endmodule

>>> rtl/obo_checker.sv
// port checker for the opening overlay block, bound to the top level
`include "assert_macros.svh"

module obo_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [obo_pkg::PIX_W-1:0] red,
  input logic [obo_pkg::PIX_W-1:0] green,
  input logic [obo_pkg::PIX_W-1:0] blue,
  input logic                      frame_last
);
  import obo_pkg::*;

  // a stalled result keeps its payload
  `ASSERT_CLK(a_res_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) && $stable(blue) && $stable(frame_last), "stalled result changed")

  // every new result follows an accepted request
  `ASSERT_CLK(a_res_cause, clk, rst, $rose(out_valid) |-> $past(in_valid && in_ready), "result without request")

  // no request taken while a result waits and is not drained
  `ASSERT_NEVER(a_no_overrun, clk, rst, out_valid && !out_ready && in_ready, "request taken over a blocked result")

  // red and green show either the gray value or full scale
  `ASSERT_CLK(a_overlay, clk, rst, out_valid |-> (red == blue || red == PIX_FULL) && (green == blue || green == PIX_FULL), "overlay channel corrupt")
endmodule

bind binary_opening_boundary_overlay_unit obo_checker u_obo_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pixels.valid),
  .in_ready   (pixels.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .red        (results.red),
  .green      (results.green),
  .blue       (results.blue),
  .frame_last (results.frame_last)
);
